@@ sv/kld_pkg.sv @@
// Package for the keyboard link device side: transfer payload types, command codes,
// frame codes and the reply frame builder.
// Depends on nothing; imported by every module of the block.
package kld_pkg;

	// Command codes carried in the command field.
	localparam logic [2:0] CMD_START_RX = 3'd0;
	localparam logic [2:0] CMD_RX_TICK  = 3'd1;
	localparam logic [2:0] CMD_LOAD_KBD = 3'd2;
	localparam logic [2:0] CMD_LOAD_MOU = 3'd3;
	localparam logic [2:0] CMD_START_TX = 3'd4;
	localparam logic [2:0] CMD_TX_TICK  = 3'd5;
	localparam logic [2:0] CMD_READ     = 3'd6;

	// Pending query kinds.
	localparam logic [1:0] QUERY_NONE  = 2'd0;
	localparam logic [1:0] QUERY_KBD   = 2'd1;
	localparam logic [1:0] QUERY_MOUSE = 2'd2;

	// Receive frame geometry and codes.
	localparam int         RX_W             = 15;
	localparam logic [3:0] RX_FRAME_TICKS   = 4'd15;
	localparam logic [3:0] RX_QUERY_TICK    = 4'd5;
	localparam logic [14:0] CODE_KBD_QUERY   = 15'h0020;
	localparam logic [14:0] CODE_MOUSE_QUERY = 15'h0022;
	localparam logic [14:0] CODE_RESET       = 15'h0fde;
	localparam logic [12:0] CODE_LED         = 13'h0e00;

	// Idle reply frame sent when a query finds no data waiting.
	localparam logic [20:0] CODE_IDLE = 21'h100600;

	typedef struct packed {
		logic [2:0] command;
		logic       line_level;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
	} cmd_t;

	typedef struct packed {
		logic        tx_level;
		logic        tx_done;
		logic        rx_done;
		logic        rx_early;
		logic [1:0]  query_kind;
		logic        reset_seen;
		logic [1:0]  led_bits;
		logic [14:0] latest_frame;
	} rsp_t;

	typedef struct packed {
		logic        rx_done;
		logic        rx_early;
		logic [1:0]  query_kind;
		logic        reset_seen;
		logic [1:0]  led_bits;
		logic [14:0] latest_frame;
	} rx_status_t;

	typedef struct packed {
		logic tx_level;
		logic tx_done;
	} tx_status_t;

	// Data reply: first byte in bits 8:1, the data mark in bit 10, second byte in bits 19:12.
	function automatic logic [19:0] data_frame(input logic [15:0] bytes);
		return {bytes[15:8], 1'b0, 1'b1, 1'b0, bytes[7:0], 1'b0};
	endfunction

endpackage

@@ sv/kld_rx.sv @@
// Receiver of the keyboard link device side: frame sampling, query detection,
// frame close, LED and reset latches, and the read of the last frame.
// Depends on kld_pkg.
module kld_rx
	import kld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  cmd_t       cmd,
	output logic [1:0] query_now,
	output rx_status_t status
);

	logic [RX_W-1:0] shift_q, shift_n, sampled;
	logic [3:0]      cnt_q, cnt_n;
	logic            active_q, active_n;
	logic [1:0]      query_q, query_n;
	logic [RX_W-1:0] frame_q, frame_n;
	logic [1:0]      led_q, led_n;
	logic            reset_q, reset_n;
	logic            done, early;
	logic [RX_W-1:0] latest;

	always_comb begin
		sampled  = shift_q | (RX_W'(cmd.line_level) << cnt_q);
		shift_n  = shift_q;
		cnt_n    = cnt_q;
		active_n = active_q;
		query_n  = query_q;
		frame_n  = frame_q;
		led_n    = led_q;
		reset_n  = reset_q;
		done     = 1'b0;
		early    = 1'b0;
		latest   = '0;
		unique case (cmd.command)
			CMD_START_RX: begin
				shift_n  = '0;
				cnt_n    = '0;
				query_n  = QUERY_NONE;
				active_n = 1'b1;
			end
			CMD_RX_TICK: begin
				if (active_q) begin
					if (cnt_q == 4'd0) begin
						cnt_n = 4'd1;
					end else if (cnt_q >= RX_FRAME_TICKS) begin
						active_n = 1'b0;
						done     = 1'b1;
						frame_n  = shift_q;
						if (shift_q == CODE_RESET) begin
							reset_n = 1'b1;
						end else if (shift_q[12:0] == CODE_LED) begin
							led_n = shift_q[14:13];
						end
					end else begin
						shift_n = sampled;
						if (cnt_q == RX_QUERY_TICK &&
						    (sampled == CODE_MOUSE_QUERY || sampled == CODE_KBD_QUERY)) begin
							query_n  = (sampled == CODE_MOUSE_QUERY) ? QUERY_MOUSE : QUERY_KBD;
							active_n = 1'b0;
							done     = 1'b1;
							early    = 1'b1;
						end else begin
							cnt_n = cnt_q + 4'd1;
						end
					end
				end
			end
			CMD_READ: begin
				frame_n = '0;
				latest  = (query_q != QUERY_NONE || frame_q == CODE_RESET) ? '0 : frame_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= '0;
			cnt_q    <= '0;
			active_q <= 1'b0;
			query_q  <= QUERY_NONE;
			frame_q  <= '0;
			led_q    <= '0;
			reset_q  <= 1'b0;
		end else if (step) begin
			shift_q  <= shift_n;
			cnt_q    <= cnt_n;
			active_q <= active_n;
			query_q  <= query_n;
			frame_q  <= frame_n;
			led_q    <= led_n;
			reset_q  <= reset_n;
		end
	end

	assign query_now           = query_q;
	assign status.rx_done      = done;
	assign status.rx_early     = early;
	assign status.query_kind   = query_n;
	assign status.reset_seen   = reset_n;
	assign status.led_bits     = led_n;
	assign status.latest_frame = latest;

endmodule

@@ sv/kld_tx.sv @@
// Transmitter of the keyboard link device side: keyboard and mouse data holding,
// reply frame selection and the bit-by-bit shift-out.
// Depends on kld_pkg.
module kld_tx
	import kld_pkg::*;
#(
	parameter int TX_FRAME_BITS = 21
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  cmd_t       cmd,
	input  logic [1:0] query_now,
	output tx_status_t status
);

	localparam int CW = $clog2(TX_FRAME_BITS + 1);

	logic [TX_FRAME_BITS-1:0] shift_q, shift_n;
	logic [CW-1:0]            cnt_q, cnt_n;
	logic                     active_q, active_n;
	logic [15:0]              kbd_q, kbd_n, mou_q, mou_n;
	logic                     kbd_pend_q, kbd_pend_n, mou_pend_q, mou_pend_n;
	logic                     level, done;

	always_comb begin
		shift_n    = shift_q;
		cnt_n      = cnt_q;
		active_n   = active_q;
		kbd_n      = kbd_q;
		mou_n      = mou_q;
		kbd_pend_n = kbd_pend_q;
		mou_pend_n = mou_pend_q;
		level      = 1'b1;
		done       = 1'b0;
		unique case (cmd.command)
			CMD_LOAD_KBD: begin
				kbd_n      = {cmd.second_byte, cmd.first_byte};
				kbd_pend_n = 1'b1;
			end
			CMD_LOAD_MOU: begin
				mou_n      = {cmd.second_byte, cmd.first_byte};
				mou_pend_n = 1'b1;
			end
			CMD_START_TX: begin
				cnt_n    = '0;
				active_n = 1'b1;
				if (query_now == QUERY_KBD) begin
					if (kbd_pend_q) begin
						shift_n    = TX_FRAME_BITS'(data_frame(kbd_q));
						kbd_pend_n = 1'b0;
					end else begin
						shift_n = TX_FRAME_BITS'(CODE_IDLE);
					end
				end else if (query_now == QUERY_MOUSE) begin
					if (mou_pend_q) begin
						shift_n    = TX_FRAME_BITS'(data_frame(mou_q));
						mou_pend_n = 1'b0;
					end else begin
						shift_n = TX_FRAME_BITS'(CODE_IDLE);
					end
				end else begin
					shift_n = '1;
				end
			end
			CMD_TX_TICK: begin
				if (active_q) begin
					if (cnt_q >= CW'(TX_FRAME_BITS)) begin
						active_n = 1'b0;
						done     = 1'b1;
					end else begin
						level   = shift_q[0];
						shift_n = shift_q >> 1;
						cnt_n   = cnt_q + CW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= '1;
			cnt_q      <= '0;
			active_q   <= 1'b0;
			kbd_q      <= '0;
			mou_q      <= '0;
			kbd_pend_q <= 1'b0;
			mou_pend_q <= 1'b0;
		end else if (step) begin
			shift_q    <= shift_n;
			cnt_q      <= cnt_n;
			active_q   <= active_n;
			kbd_q      <= kbd_n;
			mou_q      <= mou_n;
			kbd_pend_q <= kbd_pend_n;
			mou_pend_q <= mou_pend_n;
		end
	end

	assign status.tx_level = level;
	assign status.tx_done  = done;

endmodule

@@ sv/keyboard_link_device_side.sv @@
// Top level of the keyboard link device side: command and response registers around
// the receiver and transmitter.
// Depends on kld_pkg, kld_rx and kld_tx.
//
//  Channel   Signals                        Direction  Payload
//  command   cmd_valid, cmd_ready, cmd      in         cmd_t: one command per transfer
//  response  rsp_valid, rsp_ready, rsp      out        rsp_t: one result per command
//
// Every command is held in the command register and is then offered from the response
// register. The block takes one command per clock while the response side does not
// stall; a new transfer is taken in the same cycle as a response leaves.
// A stalled response holds the command register, and cmd_ready falls only when
// both registers are full. Reset empties both registers, sets the transmit shift
// register to all ones and clears every other state register.
module keyboard_link_device_side
	import kld_pkg::*;
#(
	parameter int TX_FRAME_BITS = 21
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// The command register holds one accepted command until its result can be
	// written into the response register.
	cmd_t       cmd_s1;
	logic       valid_s1;
	logic       advance;
	logic [1:0] query_now;
	rx_status_t rx_status;
	tx_status_t tx_status;
	rsp_t       rsp_s2;
	logic       valid_s2;

	// The state of the link moves on only when a command leaves the command
	// register, so results stay in the order of the transfers whatever the stalls.
	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign cmd_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

	kld_rx u_rx (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.cmd       (cmd_s1),
		.query_now (query_now),
		.status    (rx_status)
	);

	kld_tx #(
		.TX_FRAME_BITS (TX_FRAME_BITS)
	) u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.cmd       (cmd_s1),
		.query_now (query_now),
		.status    (tx_status)
	);

	// The response register keeps a finished result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2.tx_level     <= tx_status.tx_level;
			rsp_s2.tx_done      <= tx_status.tx_done;
			rsp_s2.rx_done      <= rx_status.rx_done;
			rsp_s2.rx_early     <= rx_status.rx_early;
			rsp_s2.query_kind   <= rx_status.query_kind;
			rsp_s2.reset_seen   <= rx_status.reset_seen;
			rsp_s2.led_bits     <= rx_status.led_bits;
			rsp_s2.latest_frame <= rx_status.latest_frame;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	// An early end is always a frame end.
	a_early_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.rx_early |-> rsp_s2.rx_done)
		else $error("early frame end without frame end");

	// The transmitter never drives the line low on the tick that closes its frame.
	a_tx_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.tx_done |-> rsp_s2.tx_level)
		else $error("line low on transmit frame end");

	// A frame read comes only from a read command, which ends no frame.
	a_read_alone: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.latest_frame != '0 |-> !rsp_s2.rx_done && !rsp_s2.tx_done)
		else $error("frame read together with a frame end");

	// Back-pressure reaches the command side only when both registers are full.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> valid_s1 && valid_s2 && !rsp_ready)
		else $error("command side stalled with room to spare");

	// A query kind of three cannot arise.
	a_query_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> rsp_s2.query_kind != 2'd3)
		else $error("undefined query kind");

endmodule
